// ----- rtl/core/bottom_up_merge_sort_descending_assert.svh -----
// assertion macros shared by the merge sort rtl
`ifndef BOTTOM_UP_MERGE_SORT_DESCENDING_ASSERT_SVH
`define BOTTOM_UP_MERGE_SORT_DESCENDING_ASSERT_SVH

// same-cycle implication, sampled on i_clk, off during reset
`define BUMS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on i_clk, off during reset
`define BUMS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/bums_pkg.sv -----
// shared types and constants of the merge sort block
package bums_pkg;

    // field widths of one record
    localparam int THREE_W = 14;
    localparam int TWO_W   = 14;
    localparam int RANK_W  = 8;

    // default capacity of the record store
    localparam int MAX_RECORDS_DEF = 32;

    // configuration port
    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    // register index of the key select register
    localparam logic REG_SORT_KEY = 1'b0;

    // reset value of the key select: sort by three-point percentage
    localparam logic KEY_SEL_RESET = 1'b1;

    // one stored record
    typedef struct packed {
        logic [THREE_W-1:0] three;
        logic [TWO_W-1:0]   two;
        logic [RANK_W-1:0]  rank;
    } t_rec;

endpackage

// ----- rtl/core/bums_ram.sv -----
// record memory: one write port, two registered read ports
module bums_ram #(
    parameter int DEPTH = bums_pkg::MAX_RECORDS_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  bums_pkg::t_rec  i_wdata,
    input  logic [AW-1:0]   i_raddr_a,
    input  logic [AW-1:0]   i_raddr_b,
    output bums_pkg::t_rec  o_rdata_a,
    output bums_pkg::t_rec  o_rdata_b
);

    bums_pkg::t_rec r_mem [DEPTH];
    bums_pkg::t_rec r_rdata_a;
    bums_pkg::t_rec r_rdata_b;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read ports
    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

// ----- rtl/core/bums_cmp.sv -----
// shared key compare unit: decides whether the left run head goes first
module bums_cmp (
    input  logic           i_key_sel,
    input  bums_pkg::t_rec i_left,
    input  bums_pkg::t_rec i_right,
    output logic           o_left_first
);

    logic [bums_pkg::THREE_W-1:0] key_left;
    logic [bums_pkg::THREE_W-1:0] key_right;

    // key select: three-point or two-point percentage
    assign key_left  = i_key_sel ? i_left.three
                                 : bums_pkg::THREE_W'(i_left.two);
    assign key_right = i_key_sel ? i_right.three
                                 : bums_pkg::THREE_W'(i_right.two);

    // descending and stable: ties keep the left record first
    assign o_left_first = (key_left >= key_right);

endmodule

// ----- rtl/core/bottom_up_merge_sort_descending.sv -----
// Loading: one word per cycle; a word with last set closes the set and starts the sort.
// Sort: ceil(log2 n) merge passes; each run pair opens in S_SEG, then per record S_RD
// does the registered memory read and S_WR the shared compare and write. Emit: each
// word is read, loaded and held until taken; no input is taken until the last goes.
// Reset (sync, active low) clears control, load count, overflow and valid flags; key
// select resets to 1. Memories are not cleared: only current-set entries are read.
module bottom_up_merge_sort_descending #(
    parameter int MAX_RECORDS = bums_pkg::MAX_RECORDS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // input channel
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [bums_pkg::THREE_W-1:0]  i_three_pt_pct,
    input  logic [bums_pkg::TWO_W-1:0]    i_two_pt_pct,
    input  logic [bums_pkg::RANK_W-1:0]   i_rank_in,
    input  logic                          i_last_in,
    // output channel
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bums_pkg::THREE_W-1:0]  o_three_pt_out,
    output logic [bums_pkg::TWO_W-1:0]    o_two_pt_out,
    output logic [bums_pkg::RANK_W-1:0]   o_rank_out,
    output logic                          o_last_out,
    output logic                          o_dropped,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bums_pkg::APB_AW-1:0]   paddr,
    input  logic [bums_pkg::APB_DW-1:0]   pwdata,
    output logic [bums_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    `include "bottom_up_merge_sort_descending_assert.svh"

    localparam int IW = $clog2(MAX_RECORDS);
    localparam int CW = $clog2(MAX_RECORDS + 1);
    localparam int WW = CW + 1;
    localparam int SW = CW + 2;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_RECORDS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_SEG,
        S_RD,
        S_WR,
        S_EMIT_RD,
        S_EMIT_LD,
        S_EMIT_WAIT
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_n, n_n;
    logic          r_drop, n_drop;
    logic          r_key_sel;
    logic          r_key_act, n_key_act;
    logic [WW-1:0] r_width, n_width;
    logic [CW-1:0] r_lo, n_lo;
    logic [CW-1:0] r_mid, n_mid;
    logic [CW-1:0] r_hi, n_hi;
    logic [CW-1:0] r_i, n_i;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic          r_src, n_src;
    logic          r_out_valid, n_out_valid;
    logic          r_out_last, n_out_last;
    bums_pkg::t_rec r_out_rec, n_out_rec;

    logic           in_acc;
    logic           has_room;
    logic [CW-1:0]  load_n;
    logic [SW-1:0]  lo_plus_w;
    logic [SW-1:0]  lo_plus_2w;
    logic [SW-1:0]  width_x2;
    logic [CW-1:0]  seg_mid;
    logic [CW-1:0]  seg_hi;
    logic [CW-1:0]  k_inc;
    logic           left_ok;
    logic           right_ok;
    logic           left_first;
    logic           take_left;
    logic           emitting;
    bums_pkg::t_rec in_rec;
    bums_pkg::t_rec merged_rec;
    bums_pkg::t_rec head_left;
    bums_pkg::t_rec head_right;
    bums_pkg::t_rec rda_a, rda_b, rdb_a, rdb_b;

    logic           we_a, we_b;
    logic [IW-1:0]  waddr_a;
    bums_pkg::t_rec wdata_a;
    logic [IW-1:0]  raddr_a;

    // configuration register, written on the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_sel <= bums_pkg::KEY_SEL_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == bums_pkg::REG_SORT_KEY)) begin
            r_key_sel <= pwdata[0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == bums_pkg::REG_SORT_KEY) ?
                    bums_pkg::APB_DW'(r_key_sel) : '0;

    // input word and handshakes
    assign in_rec   = '{three: i_three_pt_pct, two: i_two_pt_pct, rank: i_rank_in};
    assign o_ready  = (r_state == S_LOAD);
    assign in_acc   = i_valid && o_ready;
    assign has_room = (r_count < MAX_C);
    assign load_n   = has_room ? (r_count + ONE_C) : r_count;

    // run bounds of the next segment
    assign lo_plus_w  = SW'(r_lo) + SW'(r_width);
    assign lo_plus_2w = SW'(r_lo) + SW'({r_width, 1'b0});
    assign width_x2   = SW'({r_width, 1'b0});
    assign seg_mid    = (lo_plus_w  < SW'(r_n)) ? lo_plus_w[CW-1:0]  : r_n;
    assign seg_hi     = (lo_plus_2w < SW'(r_n)) ? lo_plus_2w[CW-1:0] : r_n;
    assign k_inc      = r_k + ONE_C;

    // run heads from the memory that holds the current pass
    assign head_left  = r_src ? rdb_a : rda_a;
    assign head_right = r_src ? rdb_b : rda_b;

    bums_cmp u_cmp (
        .i_key_sel    (r_key_act),
        .i_left       (head_left),
        .i_right      (head_right),
        .o_left_first (left_first)
    );

    assign left_ok    = (r_i < r_mid);
    assign right_ok   = (r_j < r_hi);
    assign take_left  = left_ok && (!right_ok || left_first);
    assign merged_rec = take_left ? head_left : head_right;

    // memory ports: A takes loads, passes alternate between A and B
    assign emitting = (r_state == S_EMIT_RD) || (r_state == S_EMIT_LD) ||
                      (r_state == S_EMIT_WAIT);
    assign raddr_a  = emitting ? r_k[IW-1:0] : r_i[IW-1:0];
    assign we_a     = ((r_state == S_LOAD) && in_acc && has_room) ||
                      ((r_state == S_WR) && r_src);
    assign waddr_a  = (r_state == S_LOAD) ? r_count[IW-1:0] : r_k[IW-1:0];
    assign wdata_a  = (r_state == S_LOAD) ? in_rec : merged_rec;
    assign we_b     = (r_state == S_WR) && !r_src;

    bums_ram #(.DEPTH(MAX_RECORDS), .AW(IW)) u_ram_a (
        .i_clk     (i_clk),
        .i_we      (we_a),
        .i_waddr   (waddr_a),
        .i_wdata   (wdata_a),
        .i_raddr_a (raddr_a),
        .i_raddr_b (r_j[IW-1:0]),
        .o_rdata_a (rda_a),
        .o_rdata_b (rda_b)
    );

    bums_ram #(.DEPTH(MAX_RECORDS), .AW(IW)) u_ram_b (
        .i_clk     (i_clk),
        .i_we      (we_b),
        .i_waddr   (r_k[IW-1:0]),
        .i_wdata   (merged_rec),
        .i_raddr_a (raddr_a),
        .i_raddr_b (r_j[IW-1:0]),
        .o_rdata_a (rdb_a),
        .o_rdata_b (rdb_b)
    );

    // sequencer: load, merge passes, emit
    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_ovf       = r_ovf;
        n_n         = r_n;
        n_drop      = r_drop;
        n_key_act   = r_key_act;
        n_width     = r_width;
        n_lo        = r_lo;
        n_mid       = r_mid;
        n_hi        = r_hi;
        n_i         = r_i;
        n_j         = r_j;
        n_k         = r_k;
        n_src       = r_src;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        n_out_rec   = r_out_rec;
        case (r_state)
            S_LOAD: begin
                if (in_acc) begin
                    n_count = load_n;
                    n_ovf   = r_ovf || !has_room;
                    if (i_last_in) begin
                        // close the set and start with runs of one
                        n_n       = load_n;
                        n_drop    = r_ovf || !has_room;
                        n_key_act = r_key_sel;
                        n_count   = '0;
                        n_ovf     = 1'b0;
                        n_width   = WW'(1);
                        n_lo      = '0;
                        n_src     = 1'b0;
                        n_k       = '0;
                        n_state   = (load_n > ONE_C) ? S_SEG : S_EMIT_RD;
                    end
                end
            end
            S_SEG: begin
                n_mid   = seg_mid;
                n_hi    = seg_hi;
                n_i     = r_lo;
                n_j     = seg_mid;
                n_k     = r_lo;
                n_state = S_RD;
            end
            S_RD: begin
                // wait for the registered run heads
                n_state = S_WR;
            end
            S_WR: begin
                if (take_left) begin
                    n_i = r_i + ONE_C;
                end else begin
                    n_j = r_j + ONE_C;
                end
                n_k = k_inc;
                if (k_inc == r_hi) begin
                    if (r_hi == r_n) begin
                        // pass done: swap memories and double the run width
                        n_src   = !r_src;
                        n_lo    = '0;
                        n_width = width_x2[WW-1:0];
                        if (width_x2 < SW'(r_n)) begin
                            n_state = S_SEG;
                        end else begin
                            n_k     = '0;
                            n_state = S_EMIT_RD;
                        end
                    end else begin
                        n_lo    = r_hi;
                        n_state = S_SEG;
                    end
                end else begin
                    n_state = S_RD;
                end
            end
            S_EMIT_RD: begin
                n_state = S_EMIT_LD;
            end
            S_EMIT_LD: begin
                n_out_rec   = head_left;
                n_out_last  = (k_inc == r_n);
                n_out_valid = 1'b1;
                n_state     = S_EMIT_WAIT;
            end
            S_EMIT_WAIT: begin
                if (i_ready) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_LOAD;
                    end else begin
                        n_k     = k_inc;
                        n_state = S_EMIT_RD;
                    end
                end
            end
            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_out_valid <= 1'b0;
            r_src       <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_ovf       <= n_ovf;
            r_out_valid <= n_out_valid;
            r_src       <= n_src;
        end
        r_n        <= n_n;
        r_drop     <= n_drop;
        r_key_act  <= n_key_act;
        r_width    <= n_width;
        r_lo       <= n_lo;
        r_mid      <= n_mid;
        r_hi       <= n_hi;
        r_i        <= n_i;
        r_j        <= n_j;
        r_k        <= n_k;
        r_out_last <= n_out_last;
        r_out_rec  <= n_out_rec;
    end

    // output word
    assign o_valid        = r_out_valid;
    assign o_three_pt_out = r_out_rec.three;
    assign o_two_pt_out   = r_out_rec.two;
    assign o_rank_out     = r_out_rec.rank;
    assign o_last_out     = r_out_last;
    assign o_dropped      = r_drop;

    // checks
    `BUMS_ASSERT_NOW(a_count_bound, 1'b1, r_count <= MAX_C, "record count above capacity")
    `BUMS_ASSERT_NOW(a_merge_ptrs, r_state == S_WR,
        (r_k < r_hi) && (r_i <= r_mid) && (r_j <= r_hi) && (r_mid <= r_hi),
        "merge pointers out of their runs")
    `BUMS_ASSERT_NOW(a_out_blocks_in, o_valid, !o_ready, "input taken while a word is pending")
    `BUMS_ASSERT_NEXT(a_set_closed, o_valid && i_ready && o_last_out,
        (r_state == S_LOAD) && (r_count == '0) && !r_ovf && !o_valid,
        "block not ready for a new set after the last word")

endmodule
